// ----- rtl/core/cdo_pkg.sv -----
// shared widths, constants, types and calendar tables for the date offset unit
`timescale 1ns / 1ps

package cdo_pkg;

   // default year window
   localparam int FIRST_YEAR_DEF = 2000;
   localparam int LAST_YEAR_DEF  = 2030;

   // port field widths
   localparam int YEAR_W       = 11;
   localparam int MONTH_W      = 4;
   localparam int DAY_W        = 5;
   localparam int OFF_W        = 15;
   localparam int SERIAL_OUT_W = 14;

   // internal widths, sized for a window of at most 100 years
   localparam int DIFF_W = 7;   // year minus first year
   localparam int DOY_W  = 9;   // day of year
   localparam int SER_W  = 16;  // serial inside the window
   localparam int SUM_W  = 18;  // signed serial plus offset
   localparam int GRP_W  = 11;  // day within a four year group
   localparam int Q_W    = 5;   // four year group number
   localparam int YO_W   = 2;   // year within a group

   // calendar constants
   localparam int DAYS_PER_YEAR  = 365;
   localparam int DAYS_PER_GROUP = 4 * DAYS_PER_YEAR + 1;
   localparam int YEAR1_START    = DAYS_PER_YEAR + 1;
   localparam int YEAR2_START    = YEAR1_START + DAYS_PER_YEAR;
   localparam int YEAR3_START    = YEAR2_START + DAYS_PER_YEAR;

   // reciprocal of the group length, floor so the estimate never overshoots
   localparam int RECIP_SHIFT = 22;
   localparam int RECIP_W     = 12;
   localparam int RECIP       = (1 << RECIP_SHIFT) / DAYS_PER_GROUP;
   localparam int PROD_W      = SER_W + RECIP_W;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // stage 2 to stage 3 handoff
   typedef struct packed {
      logic             input_valid;
      logic             in_range;
      logic [SER_W-1:0] serial;
      logic [SER_W-1:0] rem;
   } serial_type;

   // stage 4 to stage 5 handoff
   typedef struct packed {
      logic             input_valid;
      logic             in_range;
      logic [SER_W-1:0] serial;
      logic [Q_W-1:0]   grp;
      logic [GRP_W-1:0] grp_day;
   } split_type;

   // month length, month must be 1..12 to be meaningful
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] n;
      unique case (m)
         4'd2:                      n = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
         default:                   n = 5'd31;
      endcase
      return n;
   endfunction

   // days in the year before the first of month m
   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
      logic [DOY_W-1:0] n;
      unique case (m)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      if (leap && m > MONTH_FEB && m <= MONTH_DEC) begin
         n = n + 9'd1;
      end
      return n;
   endfunction

endpackage

// ----- rtl/core/cdo_to_serial.sv -----
// stages 1 and 2: date check and conversion of date plus offset to a serial
`timescale 1ns / 1ps

module cdo_to_serial #(
   parameter int FIRST_YEAR = cdo_pkg::FIRST_YEAR_DEF,
   parameter int LAST_YEAR  = cdo_pkg::LAST_YEAR_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [cdo_pkg::YEAR_W-1:0]       in_year,
   input  logic [cdo_pkg::MONTH_W-1:0]      in_month,
   input  logic [cdo_pkg::DAY_W-1:0]        in_day,
   input  logic signed [cdo_pkg::OFF_W-1:0] day_offset,
   output logic                             out_valid,
   input  logic                             out_ready,
   output cdo_pkg::serial_type              out_data
);

   localparam int LAST_DIFF   = LAST_YEAR - FIRST_YEAR;
   localparam int LAST_SERIAL = LAST_DIFF * cdo_pkg::DAYS_PER_YEAR + (LAST_DIFF + 3) / 4
                                + cdo_pkg::DAYS_PER_YEAR + ((LAST_DIFF % 4 == 0) ? 1 : 0);

   logic s1_en, s2_en;
   logic s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;

   // stage 1 payload
   logic                               s1_ok_ff, s1_ok_in;
   logic [cdo_pkg::DIFF_W-1:0]         s1_diff_ff, s1_diff_in;
   logic [cdo_pkg::DOY_W-1:0]          s1_doy_ff, s1_doy_in;
   logic signed [cdo_pkg::OFF_W-1:0]   s1_off_ff, s1_off_in;

   cdo_pkg::serial_type s2_ff, s2_in;

   logic                       year_ok, month_ok, leap;
   logic [cdo_pkg::YEAR_W-1:0] diff_full;
   logic [cdo_pkg::SER_W-1:0]  ybase;
   logic signed [cdo_pkg::SUM_W-1:0] sum;
   logic                       in_range;

   assign s2_en     = !s2_v_ff || out_ready;
   assign s1_en     = !s1_v_ff || s2_en;
   assign in_ready  = s1_en;
   assign out_valid = s2_v_ff;
   assign out_data  = s2_ff;

   assign s1_v_in = s1_en ? in_valid : s1_v_ff;
   assign s2_v_in = s2_en ? s1_v_ff : s2_v_ff;

   // stage 1: validity and day of year
   always_comb begin
      // window bounds may lie above what the year field can hold
      year_ok   = int'(in_year) >= FIRST_YEAR &&
                  int'(in_year) <= LAST_YEAR;
      month_ok  = in_month >= cdo_pkg::MONTH_JAN && in_month <= cdo_pkg::MONTH_DEC;
      diff_full = in_year - cdo_pkg::YEAR_W'(FIRST_YEAR);
      leap      = diff_full[1:0] == 2'd0;
      s1_ok_in   = year_ok && month_ok && in_day != '0 &&
                   in_day <= cdo_pkg::month_len(in_month, leap);
      s1_diff_in = diff_full[cdo_pkg::DIFF_W-1:0];
      s1_doy_in  = cdo_pkg::days_before(in_month, leap) +
                   cdo_pkg::DOY_W'(in_day);
      s1_off_in  = day_offset;
   end

   // stage 2: year base plus day of year plus offset, window check
   always_comb begin
      ybase = cdo_pkg::SER_W'(s1_diff_ff) * cdo_pkg::SER_W'(cdo_pkg::DAYS_PER_YEAR)
              + cdo_pkg::SER_W'((cdo_pkg::SER_W'(s1_diff_ff) + 16'd3) >> 2);
      sum   = $signed({2'b00, ybase})
              + $signed({{(cdo_pkg::SUM_W - cdo_pkg::DOY_W){1'b0}}, s1_doy_ff})
              + $signed({{(cdo_pkg::SUM_W - cdo_pkg::OFF_W){s1_off_ff[cdo_pkg::OFF_W-1]}},
                         s1_off_ff});
      in_range = s1_ok_ff && sum > 18'sd0 &&
                 sum <= $signed(cdo_pkg::SUM_W'(LAST_SERIAL));
      s2_in.input_valid = s1_ok_ff;
      s2_in.in_range    = in_range;
      s2_in.serial      = in_range ? sum[cdo_pkg::SER_W-1:0] : '0;
      s2_in.rem         = in_range ? sum[cdo_pkg::SER_W-1:0] - 16'd1 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_ok_ff   <= s1_ok_in;
         s1_diff_ff <= s1_diff_in;
         s1_doy_ff  <= s1_doy_in;
         s1_off_ff  <= s1_off_in;
      end
      if (s2_en) begin
         s2_ff <= s2_in;
      end
   end

endmodule

// ----- rtl/core/cdo_year_split.sv -----
// stages 3 and 4: split the zero based serial into four year groups
`timescale 1ns / 1ps

module cdo_year_split (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  cdo_pkg::serial_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output cdo_pkg::split_type  out_data
);

   logic s3_en, s4_en;
   logic s3_v_ff, s3_v_in, s4_v_ff, s4_v_in;

   cdo_pkg::serial_type         s3_data_ff;
   logic [cdo_pkg::Q_W-1:0]     s3_q_ff, s3_q_in;
   cdo_pkg::split_type          s4_ff, s4_in;

   logic [cdo_pkg::PROD_W-1:0] prod;
   logic [cdo_pkg::SER_W-1:0]  grp_base, r0;

   assign s4_en     = !s4_v_ff || out_ready;
   assign s3_en     = !s3_v_ff || s4_en;
   assign in_ready  = s3_en;
   assign out_valid = s4_v_ff;
   assign out_data  = s4_ff;

   assign s3_v_in = s3_en ? in_valid : s3_v_ff;
   assign s4_v_in = s4_en ? s3_v_ff : s4_v_ff;

   // stage 3: group estimate by reciprocal, low by at most one
   always_comb begin
      prod    = cdo_pkg::PROD_W'(in_data.rem) *
                cdo_pkg::PROD_W'(cdo_pkg::RECIP);
      s3_q_in = prod[cdo_pkg::RECIP_SHIFT +: cdo_pkg::Q_W];
   end

   // stage 4: remainder and one correction step
   always_comb begin
      grp_base = cdo_pkg::SER_W'(s3_q_ff) * cdo_pkg::SER_W'(cdo_pkg::DAYS_PER_GROUP);
      r0       = s3_data_ff.rem - grp_base;
      s4_in.input_valid = s3_data_ff.input_valid;
      s4_in.in_range    = s3_data_ff.in_range;
      s4_in.serial      = s3_data_ff.serial;
      if (r0 >= cdo_pkg::SER_W'(cdo_pkg::DAYS_PER_GROUP)) begin
         s4_in.grp     = s3_q_ff + 5'd1;
         s4_in.grp_day = cdo_pkg::GRP_W'(r0 - cdo_pkg::SER_W'(cdo_pkg::DAYS_PER_GROUP));
      end else begin
         s4_in.grp     = s3_q_ff;
         s4_in.grp_day = r0[cdo_pkg::GRP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s3_v_in;
         s4_v_ff <= s4_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_data_ff <= in_data;
         s3_q_ff    <= s3_q_in;
      end
      if (s4_en) begin
         s4_ff <= s4_in;
      end
   end

endmodule

// ----- rtl/core/cdo_to_date.sv -----
// stages 5 and 6: year within group, then month and day; stage 6 is the output register
`timescale 1ns / 1ps

module cdo_to_date #(
   parameter int FIRST_YEAR = cdo_pkg::FIRST_YEAR_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  cdo_pkg::split_type                  in_data,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic                                input_valid,
   output logic                                result_in_range,
   output logic [cdo_pkg::YEAR_W-1:0]          out_year,
   output logic [cdo_pkg::MONTH_W-1:0]         out_month,
   output logic [cdo_pkg::DAY_W-1:0]           out_day,
   output logic [cdo_pkg::SERIAL_OUT_W-1:0]    day_serial
);

   logic s5_en, s6_en;
   logic s5_v_ff, s5_v_in, s6_v_ff, s6_v_in;

   // stage 5 payload
   logic                          s5_ok_ff, s5_range_ff;
   logic [cdo_pkg::SER_W-1:0]     s5_serial_ff;
   logic [cdo_pkg::DIFF_W-1:0]    s5_ydiff_ff, s5_ydiff_in;
   logic [cdo_pkg::DOY_W-1:0]     s5_doy_ff, s5_doy_in;
   logic                          s5_leap_ff, s5_leap_in;

   // stage 6 payload, drives the result ports
   logic                              s6_ok_ff, s6_ok_in;
   logic                              s6_range_ff, s6_range_in;
   logic [cdo_pkg::YEAR_W-1:0]        s6_year_ff, s6_year_in;
   logic [cdo_pkg::MONTH_W-1:0]       s6_month_ff, s6_month_in;
   logic [cdo_pkg::DAY_W-1:0]         s6_day_ff, s6_day_in;
   logic [cdo_pkg::SERIAL_OUT_W-1:0]  s6_serial_ff, s6_serial_in;

   logic [cdo_pkg::YO_W-1:0]    yo;
   logic [cdo_pkg::GRP_W-1:0]   ystart;
   logic [cdo_pkg::MONTH_W-1:0] mon;
   logic [cdo_pkg::DOY_W-1:0]   dom;

   assign s6_en     = !s6_v_ff || out_ready;
   assign s5_en     = !s5_v_ff || s6_en;
   assign in_ready  = s5_en;
   assign out_valid = s6_v_ff;

   assign s5_v_in = s5_en ? in_valid : s5_v_ff;
   assign s6_v_in = s6_en ? s5_v_ff : s6_v_ff;

   assign input_valid     = s6_ok_ff;
   assign result_in_range = s6_range_ff;
   assign out_year        = s6_year_ff;
   assign out_month       = s6_month_ff;
   assign out_day         = s6_day_ff;
   assign day_serial      = s6_serial_ff;

   // stage 5: the leap year opens each group
   always_comb begin
      if (in_data.grp_day < cdo_pkg::GRP_W'(cdo_pkg::YEAR1_START)) begin
         yo     = 2'd0;
         ystart = '0;
      end else if (in_data.grp_day < cdo_pkg::GRP_W'(cdo_pkg::YEAR2_START)) begin
         yo     = 2'd1;
         ystart = cdo_pkg::GRP_W'(cdo_pkg::YEAR1_START);
      end else if (in_data.grp_day < cdo_pkg::GRP_W'(cdo_pkg::YEAR3_START)) begin
         yo     = 2'd2;
         ystart = cdo_pkg::GRP_W'(cdo_pkg::YEAR2_START);
      end else begin
         yo     = 2'd3;
         ystart = cdo_pkg::GRP_W'(cdo_pkg::YEAR3_START);
      end
      s5_ydiff_in = {in_data.grp, yo};
      s5_doy_in   = cdo_pkg::DOY_W'(in_data.grp_day - ystart);
      s5_leap_in  = yo == 2'd0;
   end

   // stage 6: month by compare against the month starts
   always_comb begin
      mon = cdo_pkg::MONTH_JAN;
      for (int k = 2; k <= 12; k++) begin
         if (s5_doy_ff >= cdo_pkg::days_before(cdo_pkg::MONTH_W'(k), s5_leap_ff)) begin
            mon = cdo_pkg::MONTH_W'(k);
         end
      end
      dom = s5_doy_ff - cdo_pkg::days_before(mon, s5_leap_ff) + 9'd1;
      s6_ok_in    = s5_ok_ff;
      s6_range_in = s5_range_ff;
      if (s5_range_ff) begin
         s6_year_in   = cdo_pkg::YEAR_W'(FIRST_YEAR) + cdo_pkg::YEAR_W'(s5_ydiff_ff);
         s6_month_in  = mon;
         s6_day_in    = dom[cdo_pkg::DAY_W-1:0];
         s6_serial_in = s5_serial_ff[cdo_pkg::SERIAL_OUT_W-1:0];
      end else begin
         s6_year_in   = '0;
         s6_month_in  = '0;
         s6_day_in    = '0;
         s6_serial_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
      end else begin
         s5_v_ff <= s5_v_in;
         s6_v_ff <= s6_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_en) begin
         s5_ok_ff     <= in_data.input_valid;
         s5_range_ff  <= in_data.in_range;
         s5_serial_ff <= in_data.serial;
         s5_ydiff_ff  <= s5_ydiff_in;
         s5_doy_ff    <= s5_doy_in;
         s5_leap_ff   <= s5_leap_in;
      end
      if (s6_en) begin
         s6_ok_ff     <= s6_ok_in;
         s6_range_ff  <= s6_range_in;
         s6_year_ff   <= s6_year_in;
         s6_month_ff  <= s6_month_in;
         s6_day_ff    <= s6_day_in;
         s6_serial_ff <= s6_serial_in;
      end
   end

endmodule

// ----- rtl/core/calendar_date_day_offset_unit.sv -----
// top level of the calendar date offset unit: six stage pipeline
`timescale 1ns / 1ps

// Usage:
// A request on the req_ channel carries a start date (year, month, day) and a
// signed day offset. The rsp_ channel returns one response per request, in
// order: whether the start date was a real date inside the year window,
// whether the shifted date lies inside the window, and the shifted date with
// its day serial (January 1 of the first year is day 1). Fields other than
// the two flags read zero when either flag is low.
// A request is registered by each stage in turn, and its response is valid once
// it reaches the output register; one request is taken every cycle unless a
// stalled receiver has filled the pipe. The stages are: date check, serial
// plus offset, reciprocal estimate of the four year group, group correction,
// year within group, month and day (the output register).
// Each stage holds a valid bit and moves when the stage after it is empty or
// moving, so a stalled receiver holds the response in the output register
// while upstream stages keep filling until the pipe is full. Nothing is lost
// or repeated. Reset empties all stages; there is no state beyond the pipe.
module calendar_date_day_offset_unit #(
   parameter int FIRST_YEAR = cdo_pkg::FIRST_YEAR_DEF,
   parameter int LAST_YEAR  = cdo_pkg::LAST_YEAR_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cdo_pkg::YEAR_W-1:0]        req_in_year,
   input  logic [cdo_pkg::MONTH_W-1:0]       req_in_month,
   input  logic [cdo_pkg::DAY_W-1:0]         req_in_day,
   input  logic signed [cdo_pkg::OFF_W-1:0]  req_day_offset,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_input_valid,
   output logic                              rsp_result_in_range,
   output logic [cdo_pkg::YEAR_W-1:0]        rsp_out_year,
   output logic [cdo_pkg::MONTH_W-1:0]       rsp_out_month,
   output logic [cdo_pkg::DAY_W-1:0]         rsp_out_day,
   output logic [cdo_pkg::SERIAL_OUT_W-1:0]  rsp_day_serial
);

   logic                ser_valid, ser_ready;
   cdo_pkg::serial_type ser_data;
   logic                spl_valid, spl_ready;
   cdo_pkg::split_type  spl_data;

   cdo_to_serial #(
      .FIRST_YEAR (FIRST_YEAR),
      .LAST_YEAR  (LAST_YEAR)
   ) u_to_serial (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_year    (req_in_year),
      .in_month   (req_in_month),
      .in_day     (req_in_day),
      .day_offset (req_day_offset),
      .out_valid  (ser_valid),
      .out_ready  (ser_ready),
      .out_data   (ser_data)
   );

   cdo_year_split u_year_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ser_valid),
      .in_ready  (ser_ready),
      .in_data   (ser_data),
      .out_valid (spl_valid),
      .out_ready (spl_ready),
      .out_data  (spl_data)
   );

   cdo_to_date #(
      .FIRST_YEAR (FIRST_YEAR)
   ) u_to_date (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (spl_valid),
      .in_ready        (spl_ready),
      .in_data         (spl_data),
      .out_valid       (rsp_valid),
      .out_ready       (rsp_ready),
      .input_valid     (rsp_input_valid),
      .result_in_range (rsp_result_in_range),
      .out_year        (rsp_out_year),
      .out_month       (rsp_out_month),
      .out_day         (rsp_out_day),
      .day_serial      (rsp_day_serial)
   );

endmodule
